[rtl/qvr_pkg.sv]
// qvr_pkg: widths, constants and register codes for the quaternion vector rotator
// shared by quaternion_vector_rotate_top and qvr_checker, no dependencies
package qvr_pkg;

  // field formats
  localparam int VEC_WIDTH  = 32;                 // vector component, signed Q(VEC_WIDTH-16).16
  localparam int QUAT_WIDTH = 16;                 // quaternion part, signed Q1.(QUAT_WIDTH-2)
  localparam int FRAC2      = 2 * (QUAT_WIDTH - 2);
  localparam int NUM_AXES   = 3;

  // internal datapath widths
  localparam int SQ_W   = 2 * QUAT_WIDTH;         // product of two quaternion parts
  localparam int MAT_W  = SQ_W + 2;               // rotation matrix entry
  localparam int VLO_W  = VEC_WIDTH / 2;          // low half of a vector component
  localparam int VHI_W  = VEC_WIDTH - VLO_W;      // high half, carries the sign
  localparam int PLO_W  = MAT_W + VLO_W + 1;      // matrix entry times low half
  localparam int PHI_W  = MAT_W + VHI_W;          // matrix entry times high half
  localparam int PROD_W = MAT_W + VEC_WIDTH;      // full matrix entry times component
  localparam int ACC_W  = PROD_W + 2;             // sum of three products plus rounding

  localparam int PIPE_DEPTH = 5;                  // register stages from request to result

  // stream widths
  localparam int IN_TDATA_W  = ((NUM_AXES * VEC_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_AXES * VEC_WIDTH + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 1;

  // constants
  localparam logic [QUAT_WIDTH-1:0] QUAT_ONE =
    {2'b01, {(QUAT_WIDTH - 2){1'b0}}};
  localparam logic signed [SQ_W-1:0] SQ_ONE =
    {{(SQ_W - FRAC2 - 1){1'b0}}, 1'b1, {FRAC2{1'b0}}};
  localparam logic signed [MAT_W-1:0] MAT_ONE =
    {{(MAT_W - FRAC2 - 1){1'b0}}, 1'b1, {FRAC2{1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W - FRAC2){1'b0}}, 1'b1, {(FRAC2 - 1){1'b0}}};
  localparam logic [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X = 2'd0,
    REG_ROT_Y = 2'd1,
    REG_ROT_Z = 2'd2,
    REG_ROT_W = 2'd3
  } cfg_reg_e;

endpackage

[rtl/quaternion_vector_rotate_top.sv]
// quaternion_vector_rotate_top: rotates a stream of 3d vectors by a configured quaternion
// depends on qvr_pkg
//
// Each request carries one vector (x, y, z, signed fixed point with 16 fraction bits) and
// returns the vector part of q * v * conj(q) for the quaternion q = (rot_x, rot_y, rot_z,
// rot_w) held in the configuration registers (signed Q1.14, reset gives the identity).
// There is no normalization: a non-unit q also scales the vector by |q|^2. Each component
// is rounded once (half toward plus infinity), then saturated; the tuser bit flags any
// saturated component. The block takes one vector per clock cycle while the output is not
// stalled, and each result passes through the five register stages of the datapath:
// input capture, the 3x3 split multiplies (matrix entry times each half of a component),
// product recombine, row sum with rounding, and shift with saturation into the output
// register. Backpressure collapses bubbles stage by stage, so tready stays high whenever
// the output register is empty or being taken. The quaternion is turned into a rotation
// matrix by two register stages that run from the register's next value, so a vector
// accepted from the cycle after a register write already sees the new rotation.
module quaternion_vector_rotate_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]     cfg_wdata_i,
  // vector requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [qvr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // in_x, in_y, in_z
  // rotated vectors
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [qvr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // out_x, out_y, out_z
  output logic [qvr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser    // clipped
);
  import qvr_pkg::*;

  typedef logic signed [QUAT_WIDTH-1:0] quat_t;
  typedef logic signed [SQ_W-1:0]       sq_t;
  typedef logic signed [MAT_W-1:0]      mat_t;

  // all pairwise products of the quaternion parts
  typedef struct packed {
    sq_t xx;
    sq_t yy;
    sq_t zz;
    sq_t ww;
    sq_t xy;
    sq_t xz;
    sq_t yz;
    sq_t wx;
    sq_t wy;
    sq_t wz;
  } quat_prod_t;

  localparam int LAST = PIPE_DEPTH - 1;

  // 2 * (a + b), 2 * (a - b) and a + b - c - d at matrix width
  function automatic mat_t dbl_add(sq_t a, sq_t b);
    mat_t s;
    s = MAT_W'(a) + MAT_W'(b);
    return s <<< 1;
  endfunction

  function automatic mat_t dbl_sub(sq_t a, sq_t b);
    mat_t s;
    s = MAT_W'(a) - MAT_W'(b);
    return s <<< 1;
  endfunction

  function automatic mat_t diag(sq_t a, sq_t b, sq_t c, sq_t d);
    return MAT_W'(a) + MAT_W'(b) - MAT_W'(c) - MAT_W'(d);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers and rotation matrix
  // ---------------------------------------------------------------------------
  quat_t      rot_x_q, rot_x_d;
  quat_t      rot_y_q, rot_y_d;
  quat_t      rot_z_q, rot_z_d;
  quat_t      rot_w_q, rot_w_d;
  quat_prod_t prod_q, prod_d;
  mat_t       mat_q [NUM_AXES][NUM_AXES];
  mat_t       mat_d [NUM_AXES][NUM_AXES];

  always_comb begin
    rot_x_d = rot_x_q;
    rot_y_d = rot_y_q;
    rot_z_d = rot_z_q;
    rot_w_d = rot_w_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROT_X: rot_x_d = cfg_wdata_i;
        REG_ROT_Y: rot_y_d = cfg_wdata_i;
        REG_ROT_Z: rot_z_d = cfg_wdata_i;
        REG_ROT_W: rot_w_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // products taken from the next register value: one stage saved after a write
  always_comb begin
    prod_d.xx = SQ_W'(rot_x_d) * SQ_W'(rot_x_d);
    prod_d.yy = SQ_W'(rot_y_d) * SQ_W'(rot_y_d);
    prod_d.zz = SQ_W'(rot_z_d) * SQ_W'(rot_z_d);
    prod_d.ww = SQ_W'(rot_w_d) * SQ_W'(rot_w_d);
    prod_d.xy = SQ_W'(rot_x_d) * SQ_W'(rot_y_d);
    prod_d.xz = SQ_W'(rot_x_d) * SQ_W'(rot_z_d);
    prod_d.yz = SQ_W'(rot_y_d) * SQ_W'(rot_z_d);
    prod_d.wx = SQ_W'(rot_w_d) * SQ_W'(rot_x_d);
    prod_d.wy = SQ_W'(rot_w_d) * SQ_W'(rot_y_d);
    prod_d.wz = SQ_W'(rot_w_d) * SQ_W'(rot_z_d);
  end

  // standard rotation matrix of q, scaled by 2^FRAC2
  always_comb begin
    mat_d[0][0] = diag(prod_q.ww, prod_q.xx, prod_q.yy, prod_q.zz);
    mat_d[0][1] = dbl_sub(prod_q.xy, prod_q.wz);
    mat_d[0][2] = dbl_add(prod_q.xz, prod_q.wy);
    mat_d[1][0] = dbl_add(prod_q.xy, prod_q.wz);
    mat_d[1][1] = diag(prod_q.ww, prod_q.yy, prod_q.xx, prod_q.zz);
    mat_d[1][2] = dbl_sub(prod_q.yz, prod_q.wx);
    mat_d[2][0] = dbl_sub(prod_q.xz, prod_q.wy);
    mat_d[2][1] = dbl_add(prod_q.yz, prod_q.wx);
    mat_d[2][2] = diag(prod_q.ww, prod_q.zz, prod_q.xx, prod_q.yy);
  end

  // reset values agree with the identity quaternion at every level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q <= '0;
      rot_y_q <= '0;
      rot_z_q <= '0;
      rot_w_q <= QUAT_ONE;
      prod_q  <= '{ww: SQ_ONE, default: '0};
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          mat_q[i][j] <= (i == j) ? MAT_ONE : '0;
        end
      end
    end else begin
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
      rot_z_q <= rot_z_d;
      rot_w_q <= rot_w_d;
      prod_q  <= prod_d;
      mat_q   <= mat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage loads when empty or when the stage after it moves
  // ---------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] vld_d;
  logic [PIPE_DEPTH-1:0] ld;
  logic [PIPE_DEPTH-1:0] en;

  always_comb begin
    ld[LAST] = !vld_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
    vld_d = vld_q;
    en[0] = ld[0] && s_axis_tvalid;
    if (ld[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      en[k] = ld[k] && vld_q[k-1];
      if (ld[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = ld[0];

  // ---------------------------------------------------------------------------
  // stage 0: input capture
  // ---------------------------------------------------------------------------
  logic [VEC_WIDTH-1:0] vec_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        vec_q[j] <= s_axis_tdata[j*VEC_WIDTH +: VEC_WIDTH];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: matrix entry times the low (unsigned) and high (signed) half
  // ---------------------------------------------------------------------------
  logic signed [PLO_W-1:0] plo_d [NUM_AXES][NUM_AXES];
  logic signed [PLO_W-1:0] plo_q [NUM_AXES][NUM_AXES];
  logic signed [PHI_W-1:0] phi_d [NUM_AXES][NUM_AXES];
  logic signed [PHI_W-1:0] phi_q [NUM_AXES][NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        plo_d[i][j] = PLO_W'(mat_q[i][j]) * PLO_W'($signed({1'b0, vec_q[j][VLO_W-1:0]}));
        phi_d[i][j] = PHI_W'(mat_q[i][j]) * PHI_W'($signed(vec_q[j][VEC_WIDTH-1:VLO_W]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: recombine the halves into exact products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] mv_d [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] mv_q [NUM_AXES][NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        mv_d[i][j] = (PROD_W'(phi_q[i][j]) <<< VLO_W) + PROD_W'(plo_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mv_q <= mv_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: row sums plus half an output lsb
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_d [NUM_AXES];
  logic signed [ACC_W-1:0] acc_q [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      acc_d[i] = ACC_W'(mv_q[i][0]) + ACC_W'(mv_q[i][1]) + ACC_W'(mv_q[i][2]) + ACC_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: drop fraction bits, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] shr [NUM_AXES];
  logic [NUM_AXES-1:0]     fits;
  logic [VEC_WIDTH-1:0]    out_d [NUM_AXES];
  logic [VEC_WIDTH-1:0]    out_q [NUM_AXES];
  logic                    clip_d, clip_q;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      shr[i]  = acc_q[i] >>> FRAC2;
      // in range when every bit above the output sign matches it
      fits[i] = (&shr[i][ACC_W-1:VEC_WIDTH-1]) || !(|shr[i][ACC_W-1:VEC_WIDTH-1]);
      if (fits[i]) begin
        out_d[i] = shr[i][VEC_WIDTH-1:0];
      end else if (shr[i][ACC_W-1]) begin
        out_d[i] = VEC_MIN;
      end else begin
        out_d[i] = VEC_MAX;
      end
    end
    clip_d = !(&fits);
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      out_q  <= out_d;
      clip_q <= clip_d;
    end
  end

  assign m_axis_tvalid = vld_q[LAST];
  assign m_axis_tdata  = OUT_TDATA_W'({out_q[2], out_q[1], out_q[0]});
  assign m_axis_tuser  = OUT_TUSER_W'(clip_q);

endmodule

[rtl/qvr_checker.sv]
// qvr_checker: port-level assertions for quaternion_vector_rotate_top, bound to it below
// depends on qvr_pkg and quaternion_vector_rotate_top
module qvr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [qvr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [qvr_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import qvr_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no bubble blocks a new request while the output side is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("request refused with free output");

  // every result comes from an accepted request
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("result without request");

  // no more requests in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("too many requests in flight");

  // the clip flag only with a component at a saturation limit
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[VEC_WIDTH-1:0] == VEC_MAX ||
      m_axis_tdata[VEC_WIDTH-1:0] == VEC_MIN ||
      m_axis_tdata[2*VEC_WIDTH-1:VEC_WIDTH] == VEC_MAX ||
      m_axis_tdata[2*VEC_WIDTH-1:VEC_WIDTH] == VEC_MIN ||
      m_axis_tdata[3*VEC_WIDTH-1:2*VEC_WIDTH] == VEC_MAX ||
      m_axis_tdata[3*VEC_WIDTH-1:2*VEC_WIDTH] == VEC_MIN)
    else $error("clip flag without saturated component");

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (.*);
